// File: sv/drrp_pkg.sv
// Shared types and constants for the dirty region refresh policy unit.
// No dependencies; every other file imports this package.
package drrp_pkg;

  // Field widths
  localparam int COORD_BITS     = 12;
  localparam int SIZE_BITS      = COORD_BITS + 1;
  localparam int SCALED_BITS    = COORD_BITS + 3;   // coordinate times a scale of at most 8
  localparam int AREA_BITS      = 2 * SIZE_BITS;
  localparam int CMP_BITS       = AREA_BITS + 3;    // room for area times 5
  localparam int TIME_BITS      = 32;
  localparam int COUNT_BITS     = 8;
  localparam int GAP_BITS       = 16;
  localparam int SCALE_BITS     = 4;
  localparam int KIND_BITS      = 3;
  localparam int ACTION_BITS    = 2;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;

  // Input kinds
  localparam logic [KIND_BITS-1:0] KIND_MARK     = 3'd0;
  localparam logic [KIND_BITS-1:0] KIND_REQ_FULL = 3'd1;
  localparam logic [KIND_BITS-1:0] KIND_CLEAR    = 3'd2;
  localparam logic [KIND_BITS-1:0] KIND_FLUSH    = 3'd3;
  localparam logic [KIND_BITS-1:0] KIND_FULL_NOW = 3'd4;

  // Result actions
  localparam logic [ACTION_BITS-1:0] ACT_NONE    = 2'd0;
  localparam logic [ACTION_BITS-1:0] ACT_PARTIAL = 2'd1;
  localparam logic [ACTION_BITS-1:0] ACT_FULL    = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PANEL_WIDTH   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PANEL_HEIGHT  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SCALE_FACTOR  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_FULL_INTERVAL = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_FAST_GAP_MS   = 3'd4;

  // Configuration reset values
  localparam logic [COORD_BITS-1:0] RST_PANEL_WIDTH   = 12'd960;
  localparam logic [COORD_BITS-1:0] RST_PANEL_HEIGHT  = 12'd540;
  localparam logic [SCALE_BITS-1:0] RST_SCALE_FACTOR  = 4'd2;
  localparam logic [COUNT_BITS-1:0] RST_FULL_INTERVAL = 8'd30;
  localparam logic [GAP_BITS-1:0]   RST_FAST_GAP_MS   = 16'd800;

  localparam logic [SCALE_BITS-1:0] SCALE_MIN = 4'd1;
  localparam logic [SCALE_BITS-1:0] SCALE_MAX = 4'd8;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [KIND_BITS-1:0]  kind;
    logic [COORD_BITS-1:0] rect_x;
    logic [COORD_BITS-1:0] rect_y;
    logic [COORD_BITS-1:0] rect_w;
    logic [COORD_BITS-1:0] rect_h;
    logic [TIME_BITS-1:0]  time_ms;
  } in_item_t;

  typedef struct packed {
    logic [ACTION_BITS-1:0] action;
    logic [COORD_BITS-1:0]  upd_x;
    logic [COORD_BITS-1:0]  upd_y;
    logic [SIZE_BITS-1:0]   upd_w;
    logic [SIZE_BITS-1:0]   upd_h;
  } out_item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] panel_width;
    logic [COORD_BITS-1:0] panel_height;
    logic [SCALE_BITS-1:0] scale_factor;
    logic [COUNT_BITS-1:0] full_interval;
    logic [GAP_BITS-1:0]   fast_gap_ms;
  } cfg_t;

  // Classified item between front and back: clipped panel rectangle
  typedef struct packed {
    logic [KIND_BITS-1:0]  kind;
    logic                  mark_ok;
    logic [COORD_BITS-1:0] x_lo;
    logic [COORD_BITS-1:0] x_hi;
    logic [COORD_BITS-1:0] y_lo;
    logic [COORD_BITS-1:0] y_hi;
    logic [TIME_BITS-1:0]  time_ms;
  } qentry_t;

endpackage

// File: sv/drrp_front.sv
// Front end: accepts items, scales logical rectangles and clips them to the panel.
// Depends on drrp_pkg; feeds drrp_queue.
module drrp_front
  import drrp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      item_valid,
  output logic      item_stall,
  input  in_item_t  item,
  input  logic      q_full,
  output logic      q_push,
  output qentry_t   q_entry
);

  typedef struct packed {
    logic                  ok;
    logic [COORD_BITS-1:0] lo;
    logic [COORD_BITS-1:0] hi;
  } axis_t;

  // Clip one axis: start/len in panel pixels against the panel limit
  function automatic axis_t clip_axis(input logic [SCALED_BITS-1:0] start,
                                      input logic [SCALED_BITS-1:0] len,
                                      input logic [COORD_BITS-1:0]  limit);
    axis_t                  r;
    logic [SCALED_BITS:0]   end_pos;
    logic [SCALED_BITS:0]   lim_ext;
    lim_ext = (SCALED_BITS+1)'(limit);
    end_pos = (SCALED_BITS+1)'(start) + (SCALED_BITS+1)'(len) - (SCALED_BITS+1)'(1);
    r.ok    = (len != '0) && ((SCALED_BITS+1)'(start) < lim_ext);
    r.lo    = start[COORD_BITS-1:0];
    r.hi    = (end_pos >= lim_ext) ? (limit - COORD_BITS'(1)) : end_pos[COORD_BITS-1:0];
    return r;
  endfunction

  logic                   f1_valid;
  logic [KIND_BITS-1:0]   f1_kind;
  logic [SCALED_BITS-1:0] f1_sx, f1_sy, f1_sw, f1_sh;
  logic [TIME_BITS-1:0]   f1_time;

  logic [SCALE_BITS-1:0]  scale_eff;
  logic [SCALED_BITS-1:0] sx_next, sy_next, sw_next, sh_next;
  logic                   item_take;
  axis_t                  ax, ay;

  assign item_stall = f1_valid && q_full;
  assign item_take  = item_valid && !item_stall;
  assign q_push     = f1_valid && !q_full;

  // Scale factor outside 1..8 is clamped
  always_comb begin
    if (cfg.scale_factor < SCALE_MIN) begin
      scale_eff = SCALE_MIN;
    end else if (cfg.scale_factor > SCALE_MAX) begin
      scale_eff = SCALE_MAX;
    end else begin
      scale_eff = cfg.scale_factor;
    end
  end

  // Clear and full-now mark the whole panel; marks are scaled
  always_comb begin
    case (item.kind) inside
      KIND_CLEAR, KIND_FULL_NOW: begin
        sx_next = '0;
        sy_next = '0;
        sw_next = SCALED_BITS'(cfg.panel_width);
        sh_next = SCALED_BITS'(cfg.panel_height);
      end
      default: begin
        sx_next = SCALED_BITS'(item.rect_x) * SCALED_BITS'(scale_eff);
        sy_next = SCALED_BITS'(item.rect_y) * SCALED_BITS'(scale_eff);
        sw_next = SCALED_BITS'(item.rect_w) * SCALED_BITS'(scale_eff);
        sh_next = SCALED_BITS'(item.rect_h) * SCALED_BITS'(scale_eff);
      end
    endcase
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (item_take) begin
      f1_valid <= 1'b1;
    end else if (q_push) begin
      f1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      f1_kind <= item.kind;
      f1_sx   <= sx_next;
      f1_sy   <= sy_next;
      f1_sw   <= sw_next;
      f1_sh   <= sh_next;
      f1_time <= item.time_ms;
    end
  end

  // Clip and build the queue entry
  always_comb begin
    ax = clip_axis(f1_sx, f1_sw, cfg.panel_width);
    ay = clip_axis(f1_sy, f1_sh, cfg.panel_height);
    q_entry.kind    = f1_kind;
    q_entry.mark_ok = ax.ok && ay.ok;
    q_entry.x_lo    = ax.lo;
    q_entry.x_hi    = ax.hi;
    q_entry.y_lo    = ay.lo;
    q_entry.y_hi    = ay.hi;
    q_entry.time_ms = f1_time;
  end

endmodule

// File: sv/drrp_queue.sv
// Short FIFO between the front end and the back end.
// Depends on drrp_pkg for the entry type.
module drrp_queue
  import drrp_pkg::*;
#(
  parameter int DEPTH = 4
)
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  qentry_t push_data,
  output logic    full,
  input  logic    pop,
  output qentry_t pop_data,
  output logic    empty
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  qentry_t               entries [DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr, rd_ptr;
  logic [CNT_BITS-1:0]   count;
  logic                  do_push, do_pop;

  assign full     = (count == CNT_BITS'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entries[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + PTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_BITS'(1);
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// File: sv/drrp_back.sv
// Back end: dirty box tracking, area stage, refresh decision and output register.
// Depends on drrp_pkg; pops entries from drrp_queue.
module drrp_back
  import drrp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      q_empty,
  output logic      q_pop,
  input  qentry_t   q_data,
  output logic      result_valid,
  input  logic      result_stall,
  output out_item_t result
);

  logic en;

  // Dirty box state
  logic                  box_valid;
  logic [COORD_BITS-1:0] box_left, box_top, box_right, box_bottom;

  // Stage A: box snapshot
  logic                  sa_valid;
  logic [KIND_BITS-1:0]  sa_kind;
  logic                  sa_box_valid;
  logic [COORD_BITS-1:0] sa_left, sa_top, sa_right, sa_bottom;
  logic [TIME_BITS-1:0]  sa_time;

  // Stage B: box size and area
  logic                  sb_valid;
  logic [KIND_BITS-1:0]  sb_kind;
  logic                  sb_box_valid;
  logic [COORD_BITS-1:0] sb_x, sb_y;
  logic [SIZE_BITS-1:0]  sb_dw, sb_dh;
  logic [AREA_BITS-1:0]  sb_area;
  logic [TIME_BITS-1:0]  sb_time;

  // Panel area thresholds, recomputed every cycle from configuration
  logic [AREA_BITS-1:0]  panel_area;
  logic [CMP_BITS-1:0]   pa3, pa2;

  // Policy state
  logic                  full_latch, full_latch_next;
  logic [COUNT_BITS-1:0] partial_count, partial_count_next;
  logic [TIME_BITS-1:0]  last_flush_time, last_flush_time_next;
  logic                  flushed_before, flushed_before_next;

  // Output register
  logic                  out_valid;
  out_item_t             out_item;

  logic                  mark, is_flush;
  logic                  eff_valid;
  logic [COORD_BITS-1:0] eff_left, eff_top, eff_right, eff_bottom;
  logic [SIZE_BITS-1:0]  dw, dh;
  logic                  latch_eff, huge, fast, count_hit, go_full;
  logic [CMP_BITS-1:0]   area4, area5;
  logic [TIME_BITS-1:0]  elapsed;
  out_item_t             res;

  assign en           = !out_valid || !result_stall;
  assign q_pop        = en && !q_empty;
  assign result_valid = out_valid;
  assign result       = out_item;

  // Merge the clipped rectangle into the box
  always_comb begin
    case (q_data.kind) inside
      KIND_MARK, KIND_CLEAR, KIND_FULL_NOW: mark = q_data.mark_ok;
      default:                              mark = 1'b0;
    endcase
    is_flush  = (q_data.kind == KIND_FLUSH) || (q_data.kind == KIND_FULL_NOW);
    eff_valid = box_valid || mark;
    if (!mark) begin
      eff_left   = box_left;
      eff_top    = box_top;
      eff_right  = box_right;
      eff_bottom = box_bottom;
    end else if (!box_valid) begin
      eff_left   = q_data.x_lo;
      eff_top    = q_data.y_lo;
      eff_right  = q_data.x_hi;
      eff_bottom = q_data.y_hi;
    end else begin
      eff_left   = (q_data.x_lo < box_left)   ? q_data.x_lo : box_left;
      eff_top    = (q_data.y_lo < box_top)    ? q_data.y_lo : box_top;
      eff_right  = (q_data.x_hi > box_right)  ? q_data.x_hi : box_right;
      eff_bottom = (q_data.y_hi > box_bottom) ? q_data.y_hi : box_bottom;
    end
  end

  // Box state: a flush empties it
  always_ff @(posedge clk) begin
    if (rst) begin
      box_valid <= 1'b0;
    end else if (q_pop) begin
      box_valid <= eff_valid && !is_flush;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      box_left   <= eff_left;
      box_top    <= eff_top;
      box_right  <= eff_right;
      box_bottom <= eff_bottom;
    end
  end

  // Stage A register
  always_ff @(posedge clk) begin
    if (rst) begin
      sa_valid <= 1'b0;
    end else if (en) begin
      sa_valid <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      sa_kind      <= q_data.kind;
      sa_box_valid <= eff_valid;
      sa_left      <= eff_left;
      sa_top       <= eff_top;
      sa_right     <= eff_right;
      sa_bottom    <= eff_bottom;
      sa_time      <= q_data.time_ms;
    end
  end

  // Stage B: box dimensions and area
  assign dw = SIZE_BITS'(sa_right) - SIZE_BITS'(sa_left) + SIZE_BITS'(1);
  assign dh = SIZE_BITS'(sa_bottom) - SIZE_BITS'(sa_top) + SIZE_BITS'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      sb_valid <= 1'b0;
    end else if (en) begin
      sb_valid <= sa_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && sa_valid) begin
      sb_kind      <= sa_kind;
      sb_box_valid <= sa_box_valid;
      sb_x         <= sa_left;
      sb_y         <= sa_top;
      sb_dw        <= dw;
      sb_dh        <= dh;
      sb_area      <= AREA_BITS'(dw) * AREA_BITS'(dh);
      sb_time      <= sa_time;
    end
  end

  // Panel thresholds: 3x and 2x the panel area
  always_ff @(posedge clk) begin
    panel_area <= AREA_BITS'(cfg.panel_width) * AREA_BITS'(cfg.panel_height);
    pa3        <= (CMP_BITS'(panel_area) << 1) + CMP_BITS'(panel_area);
    pa2        <= CMP_BITS'(panel_area) << 1;
  end

  // Refresh decision
  always_comb begin
    area4     = CMP_BITS'(sb_area) << 2;
    area5     = area4 + CMP_BITS'(sb_area);
    elapsed   = sb_time - last_flush_time;
    latch_eff = full_latch || (sb_kind == KIND_FULL_NOW);
    huge      = area4 > pa3;
    fast      = flushed_before && (elapsed < TIME_BITS'(cfg.fast_gap_ms)) && (area5 > pa2);
    count_hit = partial_count >= cfg.full_interval;
    go_full   = latch_eff || huge || fast || count_hit;

    res                  = '0;
    full_latch_next      = full_latch;
    partial_count_next   = partial_count;
    last_flush_time_next = last_flush_time;
    flushed_before_next  = flushed_before;

    unique case (sb_kind) inside
      KIND_REQ_FULL, KIND_CLEAR: begin
        full_latch_next = 1'b1;
      end
      KIND_FLUSH, KIND_FULL_NOW: begin
        full_latch_next = latch_eff;
        // An empty box gives no action and leaves the count and flush time as they were
        if (sb_box_valid) begin
          if (go_full) begin
            res.action         = ACT_FULL;
            res.upd_w          = SIZE_BITS'(cfg.panel_width);
            res.upd_h          = SIZE_BITS'(cfg.panel_height);
            partial_count_next = '0;
            full_latch_next    = 1'b0;
          end else begin
            res.action = ACT_PARTIAL;
            res.upd_x  = sb_x;
            res.upd_y  = sb_y;
            res.upd_w  = sb_dw;
            res.upd_h  = sb_dh;
            if (partial_count != COUNT_MAX) begin
              partial_count_next = partial_count + COUNT_BITS'(1);
            end
          end
          last_flush_time_next = sb_time;
          flushed_before_next  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Policy state
  always_ff @(posedge clk) begin
    if (rst) begin
      full_latch      <= 1'b1;
      partial_count   <= '0;
      last_flush_time <= '0;
      flushed_before  <= 1'b0;
    end else if (en && sb_valid) begin
      full_latch      <= full_latch_next;
      partial_count   <= partial_count_next;
      last_flush_time <= last_flush_time_next;
      flushed_before  <= flushed_before_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= sb_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= res;
    end
  end

endmodule

// File: sv/dirty_region_refresh_policy_unit.sv
// Top level of the dirty region refresh policy unit: configuration registers,
// front end, queue and back end. Depends on drrp_pkg, drrp_front, drrp_queue, drrp_back.
//
// Usage:
//   item channel (item_valid/item_stall/item) carries mark, request-full, clear,
//   flush and full-now transactions; result channel (result_valid/result_stall/
//   result) returns exactly one transaction per item, in order: action none,
//   partial (box region) or full (whole panel).
//   Configuration is written through cfg_we/cfg_index/cfg_data while idle.
// Timing:
//   items pass the input register, queue, stage A, stage B and output register;
//   while result_stall is low, throughput is one item per cycle, set by the back-end
//   pipeline (box merge, area multiply, decision) advancing one transaction each cycle.
// Reset (rst, synchronous): configuration takes its defaults, the dirty box is
//   empty, the full latch is set so the first real flush is a full update.
// Stall: while result_stall holds, the result register keeps its transaction,
//   the back end freezes and the queue of QUEUE_DEPTH entries absorbs items;
//   item_stall rises only once the queue and the input register are full.
module dirty_region_refresh_policy_unit
  import drrp_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
)
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      item_valid,
  output logic                      item_stall,
  input  in_item_t                  item,
  output logic                      result_valid,
  input  logic                      result_stall,
  output out_item_t                 result
);

  cfg_t    cfg;
  logic    q_push, q_full, q_pop, q_empty;
  qentry_t q_wdata, q_rdata;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.panel_width   <= RST_PANEL_WIDTH;
      cfg.panel_height  <= RST_PANEL_HEIGHT;
      cfg.scale_factor  <= RST_SCALE_FACTOR;
      cfg.full_interval <= RST_FULL_INTERVAL;
      cfg.fast_gap_ms   <= RST_FAST_GAP_MS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PANEL_WIDTH:   cfg.panel_width   <= cfg_data[COORD_BITS-1:0];
        CFG_PANEL_HEIGHT:  cfg.panel_height  <= cfg_data[COORD_BITS-1:0];
        CFG_SCALE_FACTOR:  cfg.scale_factor  <= cfg_data[SCALE_BITS-1:0];
        CFG_FULL_INTERVAL: cfg.full_interval <= cfg_data[COUNT_BITS-1:0];
        CFG_FAST_GAP_MS:   cfg.fast_gap_ms   <= cfg_data[GAP_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  drrp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_entry    (q_wdata)
  );

  drrp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  drrp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .q_data       (q_rdata),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// File: sv/drrp_checker.sv
// Port-level checks for the dirty region refresh policy unit, bound to the top level.
// Depends on drrp_pkg and dirty_region_refresh_policy_unit.
module drrp_checker
  import drrp_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      result_valid,
  input logic      result_stall,
  input out_item_t result
);

  // A stalled result transaction is held
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // No-action results carry an all-zero region
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.action == ACT_NONE) |->
      (result.upd_x == '0) && (result.upd_y == '0) &&
      (result.upd_w == '0) && (result.upd_h == '0))
    else $error("no-action result with nonzero region");

  // Full updates start at the panel origin
  a_full_origin: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.action == ACT_FULL) |->
      (result.upd_x == '0) && (result.upd_y == '0))
    else $error("full update not at origin");

  // A partial update always covers at least one pixel
  a_partial_size: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.action == ACT_PARTIAL) |->
      (result.upd_w != '0) && (result.upd_h != '0))
    else $error("empty partial update region");

endmodule

bind dirty_region_refresh_policy_unit drrp_checker u_drrp_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

// File: tb/testbench.sv
// Self-checking testbench for dirty_region_refresh_policy_unit: directed table, then random
// phases over several panel settings, checked against an in-bench refresh decision model.
// Depends on drrp_pkg and the RTL of the unit.
module testbench;
  import drrp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Kinds the unit ignores
  localparam logic [KIND_BITS-1:0] KIND_RSVD_LO = 3'd5;
  localparam logic [KIND_BITS-1:0] KIND_RSVD_HI = 3'd7;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } stim_row_t;

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
  logic                      item_valid = 1'b0;
  logic                      item_stall;
  in_item_t                  item = '0;
  logic                      result_valid;
  logic                      result_stall = 1'b0;
  out_item_t                 result;

  dirty_region_refresh_policy_unit dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Mirror of the configuration registers
  logic [COORD_BITS-1:0] cfg_w        = RST_PANEL_WIDTH;
  logic [COORD_BITS-1:0] cfg_h        = RST_PANEL_HEIGHT;
  logic [SCALE_BITS-1:0] cfg_scale    = RST_SCALE_FACTOR;
  logic [COUNT_BITS-1:0] cfg_interval = RST_FULL_INTERVAL;
  logic [GAP_BITS-1:0]   cfg_gap      = RST_FAST_GAP_MS;

  // Dirty box and refresh bookkeeping as the unit should hold them
  bit              dirty_on = 1'b0;
  int unsigned     dirty_l = 0, dirty_t = 0, dirty_r = 0, dirty_b = 0;
  bit              force_full = 1'b1;
  int unsigned     partials = 0;
  logic [31:0]     last_flush_ms = '0;
  bit              any_flush = 1'b0;

  out_item_t       owed_updates[$];
  int unsigned     fail_count = 0;
  logic [31:0]     wall_ms = '0;
  int unsigned     burst_left = 0;

  function automatic int unsigned eff_scale();
    if (cfg_scale < SCALE_MIN) return SCALE_MIN;
    if (cfg_scale > SCALE_MAX) return SCALE_MAX;
    return cfg_scale;
  endfunction

  // Clip a panel rectangle and grow the dirty box by it
  function automatic void mark_region(int unsigned x, int unsigned y,
                                      int unsigned w, int unsigned h);
    int unsigned x1, y1;
    if (w == 0 || cfg_w == 0 || x >= cfg_w) return;
    if (h == 0 || cfg_h == 0 || y >= cfg_h) return;
    x1 = x + w - 1;
    y1 = y + h - 1;
    if (x1 >= cfg_w) x1 = cfg_w - 1;
    if (y1 >= cfg_h) y1 = cfg_h - 1;
    if (!dirty_on) begin
      dirty_l = x; dirty_t = y; dirty_r = x1; dirty_b = y1;
      dirty_on = 1'b1;
    end else begin
      if (x < dirty_l) dirty_l = x;
      if (y < dirty_t) dirty_t = y;
      if (x1 > dirty_r) dirty_r = x1;
      if (y1 > dirty_b) dirty_b = y1;
    end
  endfunction

  // Partial-or-full decision on a flush
  function automatic out_item_t flush_box(logic [31:0] now);
    out_item_t         r;
    longint unsigned   dw, dh, area, panel;
    logic [31:0]       elapsed;
    bit                go_full;
    r = '0;
    if (!dirty_on) return r;
    dw = dirty_r - dirty_l + 1;
    dh = dirty_b - dirty_t + 1;
    area = dw * dh;
    panel = longint'(cfg_w) * longint'(cfg_h);
    elapsed = now - last_flush_ms;
    go_full = force_full || (area * 4 > panel * 3) ||
              (any_flush && elapsed < cfg_gap && area * 5 > panel * 2) ||
              (partials >= cfg_interval);
    if (go_full) begin
      r.action = ACT_FULL;
      r.upd_w = cfg_w;
      r.upd_h = cfg_h;
      partials = 0;
      force_full = 1'b0;
    end else begin
      r.action = ACT_PARTIAL;
      r.upd_x = dirty_l;
      r.upd_y = dirty_t;
      r.upd_w = dw;
      r.upd_h = dh;
      if (partials < COUNT_MAX) partials++;
    end
    last_flush_ms = now;
    any_flush = 1'b1;
    dirty_on = 1'b0;
    dirty_l = 0; dirty_t = 0; dirty_r = 0; dirty_b = 0;
    return r;
  endfunction

  function automatic out_item_t refresh_decision(in_item_t t);
    int unsigned s;
    s = eff_scale();
    case (t.kind)
      KIND_MARK:
        mark_region(t.rect_x * s, t.rect_y * s, t.rect_w * s, t.rect_h * s);
      KIND_REQ_FULL:
        force_full = 1'b1;
      KIND_CLEAR: begin
        mark_region(0, 0, cfg_w, cfg_h);
        force_full = 1'b1;
      end
      KIND_FLUSH:
        return flush_box(t.time_ms);
      KIND_FULL_NOW: begin
        mark_region(0, 0, cfg_w, cfg_h);
        force_full = 1'b1;
        return flush_box(t.time_ms);
      end
      default: ;
    endcase
    return '0;
  endfunction

  function automatic out_item_t want(logic [ACTION_BITS-1:0] act, int x, int y, int w, int h);
    out_item_t r;
    r.action = act;
    r.upd_x = x;
    r.upd_y = y;
    r.upd_w = w;
    r.upd_h = h;
    return r;
  endfunction

  function automatic stim_row_t mk(logic [KIND_BITS-1:0] k, int x, int y, int w, int h,
                                   logic [31:0] t, bit typed, out_item_t exp_out);
    stim_row_t r;
    r.item.kind = k;
    r.item.rect_x = x;
    r.item.rect_y = y;
    r.item.rect_w = w;
    r.item.rect_h = h;
    r.item.time_ms = t;
    r.typed = typed;
    r.want = exp_out;
    return r;
  endfunction

  // Random transaction: mostly marks and flushes inside the panel, some noise
  function automatic in_item_t random_item();
    in_item_t    t;
    int unsigned s, lw, lh, r;
    s = eff_scale();
    lw = cfg_w / s;
    lh = cfg_h / s;
    r = $urandom_range(0, 99);
    if (r < 50)      t.kind = KIND_MARK;
    else if (r < 78) t.kind = KIND_FLUSH;
    else if (r < 83) t.kind = KIND_REQ_FULL;
    else if (r < 88) t.kind = KIND_CLEAR;
    else if (r < 94) t.kind = KIND_FULL_NOW;
    else             t.kind = $urandom_range(KIND_RSVD_LO, KIND_RSVD_HI);
    r = $urandom_range(0, 9);
    if (r < 6) begin
      t.rect_x = $urandom_range(0, lw);
      t.rect_y = $urandom_range(0, lh);
      t.rect_w = $urandom_range(1, lw / 3 + 1);
      t.rect_h = $urandom_range(1, lh / 3 + 1);
    end else if (r < 8) begin
      t.rect_x = $urandom;
      t.rect_y = $urandom;
      t.rect_w = $urandom;
      t.rect_h = $urandom;
    end else begin
      t.rect_x = $urandom_range(0, 15);
      t.rect_y = $urandom_range(0, 15);
      t.rect_w = $urandom_range(0, 2);
      t.rect_h = $urandom_range(0, 2);
    end
    // time mostly creeps forward around the fast window, sometimes jumps anywhere
    r = $urandom_range(0, 19);
    if (r == 0)      wall_ms = $urandom;
    else if (r == 1) wall_ms = wall_ms + cfg_gap;
    else if (r == 2) wall_ms = wall_ms + cfg_gap - 1;
    else             wall_ms = wall_ms + $urandom_range(0, 2 * cfg_gap + 20);
    t.time_ms = wall_ms;
    return t;
  endfunction

  // Idle cycles before the next transaction: mostly none, some short, a few long
  function automatic int unsigned next_gap();
    int unsigned r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      burst_left = $urandom_range(10, 40);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  task automatic send_item(in_item_t t, bit typed, out_item_t exp_out);
    int unsigned gap;
    out_item_t   got;
    gap = next_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item <= t;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    // accepted at this edge
    got = refresh_decision(t);
    owed_updates.push_back(typed ? exp_out : got);
  endtask

  task automatic cfg_write(logic [CFG_INDEX_BITS-1:0] idx, int unsigned val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_PANEL_WIDTH:   cfg_w = val;
      CFG_PANEL_HEIGHT:  cfg_h = val;
      CFG_SCALE_FACTOR:  cfg_scale = val;
      CFG_FULL_INTERVAL: cfg_interval = val;
      CFG_FAST_GAP_MS:   cfg_gap = val;
      default: ;
    endcase
  endtask

  // Drain the unit, then program a full register set
  task automatic apply_config(int unsigned w, int unsigned h, int unsigned s,
                              int unsigned iv, int unsigned g);
    item_valid <= 1'b0;
    while (owed_updates.size() != 0) @(posedge clk);
    cfg_write(CFG_PANEL_WIDTH, w);
    cfg_write(CFG_PANEL_HEIGHT, h);
    cfg_write(CFG_SCALE_FACTOR, s);
    cfg_write(CFG_FULL_INTERVAL, iv);
    cfg_write(CFG_FAST_GAP_MS, g);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(int unsigned n);
    for (int i = 0; i < n; i++) send_item(random_item(), 1'b0, '0);
  endtask

  // Result side backpressure: free runs, short stalls, occasional long ones
  int unsigned stall_left = 0, free_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (free_left > 0) begin
      free_left--;
      result_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      result_stall <= 1'b1;
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: free_left = $urandom_range(1, 6);
        4, 5:       free_left = $urandom_range(20, 60);
        6, 7, 8:    stall_left = $urandom_range(1, 3);
        default:    stall_left = $urandom_range(8, 30);
      endcase
      result_stall <= 1'b0;
    end
  end

  // Compare each result transaction with the oldest owed update
  always @(posedge clk) begin : check_results
    out_item_t exp_out;
    if (!rst && result_valid && !result_stall) begin
      if (owed_updates.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: act=%0d x=%0d y=%0d w=%0d h=%0d",
                   result.action, result.upd_x, result.upd_y, result.upd_w, result.upd_h);
      end else begin
        exp_out = owed_updates.pop_front();
        if (result.action !== exp_out.action || result.upd_x !== exp_out.upd_x ||
            result.upd_y !== exp_out.upd_y || result.upd_w !== exp_out.upd_w ||
            result.upd_h !== exp_out.upd_h) begin
          fail_count++;
          if (fail_count <= 10)
            $display({"result mismatch: exp act=%0d x=%0d y=%0d w=%0d h=%0d, ",
                      "got act=%0d x=%0d y=%0d w=%0d h=%0d"},
                     exp_out.action, exp_out.upd_x, exp_out.upd_y, exp_out.upd_w,
                     exp_out.upd_h, result.action, result.upd_x, result.upd_y,
                     result.upd_w, result.upd_h);
        end
      end
    end
  end

  initial begin : stimulus
    stim_row_t rows[$];
    out_item_t none, whole;
    in_item_t  t;
    none = '0;
    whole = want(ACT_FULL, 0, 0, 960, 540);

    // Directed table at reset settings: 960x540 panel, scale 2, interval 30, gap 800
    rows.push_back(mk(KIND_FLUSH, 0, 0, 0, 0, 32'd0, 1, none));          // empty box
    rows.push_back(mk(KIND_MARK, 0, 0, 10, 10, 32'd0, 1, none));
    rows.push_back(mk(KIND_FLUSH, 0, 0, 0, 0, 32'd100, 1, whole));       // first flush full
    rows.push_back(mk(KIND_MARK, 10, 20, 5, 3, 32'd0, 1, none));
    rows.push_back(mk(KIND_FLUSH, 0, 0, 0, 0, 32'd2000, 1, want(ACT_PARTIAL, 20, 40, 10, 6)));
    rows.push_back(mk(KIND_MARK, 4095, 4095, 4095, 4095, 32'd0, 1, none)); // off panel
    rows.push_back(mk(KIND_MARK, 5, 5, 0, 7, 32'd0, 1, none));           // zero width
    rows.push_back(mk(KIND_MARK, 5, 5, 7, 0, 32'd0, 1, none));           // zero height
    rows.push_back(mk(KIND_FLUSH, 0, 0, 0, 0, 32'd2100, 1, none));
    rows.push_back(mk(KIND_MARK, 470, 260, 4095, 4095, 32'd0, 0, none));  // clipped corner
    rows.push_back(mk(KIND_FLUSH, 0, 0, 0, 0, 32'd2200, 0, none));
    rows.push_back(mk(KIND_MARK, 0, 0, 4095, 4095, 32'd0, 1, none));
    rows.push_back(mk(KIND_FLUSH, 0, 0, 0, 0, 32'd2300, 1, whole));      // box covers panel
    rows.push_back(mk(KIND_REQ_FULL, 0, 0, 0, 0, 32'd0, 1, none));
    rows.push_back(mk(KIND_MARK, 1, 1, 1, 1, 32'd0, 1, none));
    rows.push_back(mk(KIND_FLUSH, 0, 0, 0, 0, 32'd5000, 1, whole));      // latched request
    rows.push_back(mk(KIND_CLEAR, 0, 0, 0, 0, 32'd0, 1, none));
    rows.push_back(mk(KIND_FLUSH, 0, 0, 0, 0, 32'd5100, 1, whole));
    rows.push_back(mk(KIND_FULL_NOW, 0, 0, 0, 0, 32'hFFFF_FFFF, 1, whole));
    rows.push_back(mk(KIND_RSVD_LO, 4095, 4095, 4095, 4095, 32'hFFFF_FFFF, 1, none));
    rows.push_back(mk(KIND_RSVD_LO + 3'd1, 1, 1, 1, 1, 32'd0, 1, none));
    rows.push_back(mk(KIND_RSVD_HI, 4095, 4095, 4095, 4095, 32'd0, 1, none));
    // large box right after a flush, across the time wrap: promoted to full
    rows.push_back(mk(KIND_MARK, 0, 0, 300, 270, 32'd0, 0, none));
    rows.push_back(mk(KIND_FLUSH, 0, 0, 0, 0, 32'd99, 0, none));
    // same box exactly one window later stays partial
    rows.push_back(mk(KIND_MARK, 0, 0, 300, 270, 32'd0, 0, none));
    rows.push_back(mk(KIND_FLUSH, 0, 0, 0, 0, 32'd899, 0, none));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) send_item(rows[i].item, rows[i].typed, rows[i].want);
    wall_ms = 32'd899;

    random_phase(50);
    // largest panel and scale, every flush forced full, widest window
    apply_config(4095, 4095, 8, 0, 65535);
    random_phase(40);
    // single pixel panel
    apply_config(1, 1, 1, 1, 1);
    random_phase(30);
    // scale below range, zero height panel: nothing can be marked
    apply_config(200, 0, 0, 3, 0);
    random_phase(30);
    // scale above range, zero width panel
    apply_config(0, 300, 15, 10, 50);
    random_phase(20);
    apply_config(640, 480, 3, 5, 300);
    random_phase(60);

    // long run of small partial updates up to the count limit
    apply_config(4095, 4095, 1, 140, 0);
    for (int i = 0; i < 150; i++) begin
      t.kind = KIND_MARK;
      t.rect_x = $urandom_range(0, 4000);
      t.rect_y = $urandom_range(0, 4000);
      t.rect_w = $urandom_range(1, 8);
      t.rect_h = $urandom_range(1, 8);
      t.time_ms = $urandom;
      send_item(t, 1'b0, '0);
      wall_ms = wall_ms + $urandom_range(0, 1000);
      t.kind = KIND_FLUSH;
      t.time_ms = wall_ms;
      send_item(t, 1'b0, '0);
    end

    item_valid <= 1'b0;
    while (owed_updates.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && owed_updates.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Hard limit on run time
  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
